// ----- hdl/stq_pkg.sv -----
// Shared types and constants of the sorted timer queue.
// Depends on nothing; every other file of the block imports it.
package stq_pkg;

    localparam int ID_W    = 4;
    localparam int PER_W   = 23;
    localparam int NOW_W   = 63;
    localparam int EXP_W   = 64;
    localparam int PROD_W  = 33;
    localparam int FIRE_W  = 6;
    localparam int US_PER_MS = 1000;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FIRED   = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        logic [EXP_W-1:0] expiry;
        logic [PER_W-1:0] period;
        logic             repeat_en;
        logic [ID_W-1:0]  ident;
        logic             valid;
    } entry_t;

    typedef struct packed {
        cell_op_t        op;
        entry_t          ins;
        logic [ID_W-1:0] ident;
    } cell_cmd_t;

endpackage

// ----- hdl/stq_in_if.sv -----
// Command channel of the sorted timer queue: valid/ready and one command item.
// Depends on stq_pkg.
interface stq_in_if;
    import stq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ID_W-1:0]   timer_id;
    logic [PER_W-1:0]  period_ms;
    logic              periodic;
    logic [NOW_W-1:0]  now_us;

    modport source (output valid, output opcode, output timer_id, output period_ms,
                    output periodic, output now_us, input ready);
    modport sink   (input valid, input opcode, input timer_id, input period_ms,
                    input periodic, input now_us, output ready);
endinterface

// ----- hdl/stq_out_if.sv -----
// Result channel of the sorted timer queue: valid/ready and one result item.
// Depends on stq_pkg.
interface stq_out_if;
    import stq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic [ID_W-1:0]   fired_id;
    logic [1:0]        status;
    logic [NOW_W-1:0]  next_delay_us;
    logic              queue_empty;
    logic              last;

    modport source (output valid, output result_kind, output fired_id, output status,
                    output next_delay_us, output queue_empty, output last, input ready);
    modport sink   (input valid, input result_kind, input fired_id, input status,
                    input next_delay_us, input queue_empty, input last, output ready);
endinterface

// ----- hdl/sorted_timer_queue_top.sv -----
// Top level of the sorted timer queue: sequencer, output register and the chain of slots.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_cell.
//
// Use: commands arrive on cmd (add, delete, tick), results leave on rsp; both are
// valid/ready channels and an item moves when valid and ready are high at a clock edge.
// Timers sit in a row of NUM_TIMERS slots kept sorted by expiry; an insert, a pop of the
// head or a delete acts on the whole row together.
// Timing: cmd.ready is high only while the sequencer is idle. An add or delete goes through
// the prepare state, then puts its acknowledgement in the output register. A tick pops the
// head once per firing; a periodic firing then runs period scaling, reload add and
// reinsert. Firings are capped at MAX_FIRES_PER_TICK; a check with nothing due leads to
// the summary. Each firing and the summary need the output register free, so a
// stalled receiver holds the sequencer at the step that would emit; a waiting result never
// blocks acceptance of the next command.
// Reset: all slots clear (queue empty), the sequencer idles and rsp.valid drops.
// Opcode 3 is taken and dropped without a result.
module sorted_timer_queue_top
#(
    parameter int NUM_TIMERS         = 16,
    parameter int MAX_FIRES_PER_TICK = 63
)
(
    input  logic clk,
    input  logic rst_n,
    stq_in_if.sink    cmd,
    stq_out_if.source rsp
);
    import stq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_ADD  = 9'b000000100,
        S_DEL  = 9'b000001000,
        S_TCHK = 9'b000010000,
        S_TMUL = 9'b000100000,
        S_TADD = 9'b001000000,
        S_TINS = 9'b010000000,
        S_TSUM = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PER_W-1:0]   per_reg, per_next;
    logic               rep_reg, rep_next;
    logic [NOW_W-1:0]   now_reg, now_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic [EXP_W-1:0]   limit_reg, limit_next;
    logic [FIRE_W-1:0]  fires_reg, fires_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         rsp_kind_reg, rsp_kind_next;
    logic [ID_W-1:0]    rsp_id_reg, rsp_id_next;
    logic [1:0]         rsp_status_reg, rsp_status_next;
    logic [NOW_W-1:0]   rsp_delay_reg, rsp_delay_next;
    logic               rsp_empty_reg, rsp_empty_next;
    logic               rsp_last_reg, rsp_last_next;

    cell_cmd_t              cell_cmd;
    entry_t                 slot [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  keep_v;
    logic [NUM_TIMERS-1:0]  match_v;
    logic [NUM_TIMERS:0]    shift_v;

    logic               out_free;
    logic               found;
    logic               full;
    logic               fire;
    logic [PER_W-1:0]   mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic [EXP_W:0]     reload_sum;
    logic [EXP_W:0]     diff;

    assign shift_v[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            entry_t left_e, right_e;
            logic   left_k;
            if (g == 0)
            begin : g_head
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = slot[g-1];
                assign left_k = keep_v[g-1];
            end
            if (g == NUM_TIMERS - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = slot[g+1];
            end

            stq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cell_cmd),
                .left_keep   (left_k),
                .left_entry  (left_e),
                .right_entry (right_e),
                .shift_in    (shift_v[g]),
                .entry       (slot[g]),
                .keep        (keep_v[g]),
                .match       (match_v[g]),
                .shift_out   (shift_v[g+1])
            );
        end
    endgenerate

    assign found    = |match_v;
    assign full     = slot[NUM_TIMERS-1].valid;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign fire     = slot[0].valid && (slot[0].expiry < limit_reg)
                      && (fires_reg < FIRE_W'(MAX_FIRES_PER_TICK));

    assign mul_a      = (state_reg == S_IDLE) ? cmd.period_ms : per_reg;
    assign mul_p      = PROD_W'(mul_a) * PROD_W'(US_PER_MS);
    assign reload_sum = {1'b0, exp_reg} + (EXP_W+1)'(prod_reg);
    assign diff       = {1'b0, slot[0].expiry} - {2'b00, now_reg};

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        per_next   = per_reg;
        rep_next   = rep_reg;
        now_next   = now_reg;
        prod_next  = prod_reg;
        exp_next   = exp_reg;
        limit_next = limit_reg;
        fires_next = fires_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_kind_next   = rsp_kind_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_status_next = rsp_status_reg;
        rsp_delay_next  = rsp_delay_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_last_next   = rsp_last_reg;

        cell_cmd.op            = CELL_HOLD;
        cell_cmd.ident         = id_reg;
        cell_cmd.ins.expiry    = exp_reg;
        cell_cmd.ins.period    = per_reg;
        cell_cmd.ins.repeat_en = rep_reg;
        cell_cmd.ins.ident     = id_reg;
        cell_cmd.ins.valid     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.opcode;
                    id_next    = cmd.timer_id;
                    per_next   = cmd.period_ms;
                    rep_next   = cmd.periodic;
                    now_next   = cmd.now_us;
                    prod_next  = mul_p;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                exp_next   = {1'b0, now_reg} + EXP_W'(prod_reg);
                limit_next = {1'b0, now_reg} + EXP_W'(US_PER_MS);
                fires_next = '0;
                case (op_reg)
                    OP_ADD:    state_next = S_ADD;
                    OP_DELETE: state_next = S_DEL;
                    OP_TICK:   state_next = S_TCHK;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    if (!found && !full)
                    begin
                        cell_cmd.op = CELL_INSERT;
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_kind_next   = KIND_ACK;
                    rsp_id_next     = id_reg;
                    rsp_status_next = (found || full) ? ST_REFUSED : ST_OK;
                    rsp_delay_next  = '0;
                    rsp_empty_next  = 1'b0;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DEL:
            begin
                if (out_free)
                begin
                    if (found)
                    begin
                        cell_cmd.op = CELL_DELETE;
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_kind_next   = KIND_ACK;
                    rsp_id_next     = id_reg;
                    rsp_status_next = found ? ST_OK : ST_NOT_FOUND;
                    rsp_delay_next  = '0;
                    rsp_empty_next  = 1'b0;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TCHK:
            begin
                if (!fire)
                begin
                    state_next = S_TSUM;
                end
                else if (out_free)
                begin
                    // Pop the head and keep its fields for a possible reload.
                    cell_cmd.op     = CELL_POP;
                    exp_next        = slot[0].expiry;
                    per_next        = slot[0].period;
                    rep_next        = slot[0].repeat_en;
                    id_next         = slot[0].ident;
                    fires_next      = fires_reg + FIRE_W'(1);
                    rsp_valid_next  = 1'b1;
                    rsp_kind_next   = KIND_FIRED;
                    rsp_id_next     = slot[0].ident;
                    rsp_status_next = ST_OK;
                    rsp_delay_next  = '0;
                    rsp_empty_next  = 1'b0;
                    rsp_last_next   = 1'b0;
                    state_next      = slot[0].repeat_en ? S_TMUL : S_TCHK;
                end
            end
            S_TMUL:
            begin
                prod_next  = mul_p;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                // Saturate the reloaded expiry on overflow.
                exp_next   = reload_sum[EXP_W] ? '1 : reload_sum[EXP_W-1:0];
                state_next = S_TINS;
            end
            S_TINS:
            begin
                cell_cmd.op = CELL_INSERT;
                state_next  = S_TCHK;
            end
            S_TSUM:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_kind_next   = KIND_SUMMARY;
                    rsp_id_next     = '0;
                    rsp_status_next = ST_OK;
                    rsp_empty_next  = !slot[0].valid;
                    rsp_last_next   = 1'b1;
                    if (!slot[0].valid || diff[EXP_W])
                    begin
                        rsp_delay_next = '0;
                    end
                    else if (diff[EXP_W-1])
                    begin
                        rsp_delay_next = '1;
                    end
                    else
                    begin
                        rsp_delay_next = diff[NOW_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            fires_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            fires_reg     <= fires_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        per_reg        <= per_next;
        rep_reg        <= rep_next;
        now_reg        <= now_next;
        prod_reg       <= prod_next;
        exp_reg        <= exp_next;
        limit_reg      <= limit_next;
        rsp_kind_reg   <= rsp_kind_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_status_reg <= rsp_status_next;
        rsp_delay_reg  <= rsp_delay_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.result_kind   = rsp_kind_reg;
    assign rsp.fired_id      = rsp_id_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.next_delay_us = rsp_delay_reg;
    assign rsp.queue_empty   = rsp_empty_reg;
    assign rsp.last          = rsp_last_reg;

endmodule

// ----- hdl/stq_cell.sv -----
// One slot of the sorted chain: holds a timer entry and moves it to or from its neighbours.
// Depends on stq_pkg.
module stq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::cell_cmd_t  cmd,
    input  logic                left_keep,
    input  stq_pkg::entry_t     left_entry,
    input  stq_pkg::entry_t     right_entry,
    input  logic                shift_in,
    output stq_pkg::entry_t     entry,
    output logic                keep,
    output logic                match,
    output logic                shift_out
);
    import stq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An equal expiry stays ahead of the newcomer, so insertion order holds.
    assign keep      = entry_reg.valid && (entry_reg.expiry <= cmd.ins.expiry);
    assign match     = entry_reg.valid && (entry_reg.ident == cmd.ident);
    assign shift_out = shift_in | match;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = left_keep ? cmd.ins : left_entry;
                end
            end
            CELL_POP:
            begin
                entry_next = right_entry;
            end
            CELL_DELETE:
            begin
                if (shift_out)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule
